### hw/rtl/gbn_pkg.sv
// Go-Back-N sender: shared types and codes.
// Used by gbn_front, gbn_back and go_back_n_sender; depends on nothing else.
`timescale 1ns / 1ps

package gbn_pkg;

    // Command codes on the input transfer
    localparam logic [1:0] CMD_NEW  = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_ACK  = 2'd2;
    localparam logic [1:0] CMD_NACK = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_QFULL = 2'd1;
    localparam logic [1:0] STAT_STALE = 2'd2;
    localparam logic [1:0] STAT_SFULL = 2'd3;

    // Sender modes; the spare code behaves as idle
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_NEW    = 2'd1;
    localparam logic [1:0] MODE_RESEND = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 7;
    localparam logic [CFG_IDX_W-1:0] REG_QLIM_ON = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QLIM    = 1'd1;
    localparam logic [CFG_W-1:0]     QLIM_RESET  = 7'd64;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] payload_tag;
        logic [15:0] peer_seq;
    } t_gbn_in;

    typedef struct packed {
        logic        send_valid;
        logic [15:0] send_seq;
        logic [31:0] send_tag;
        logic        is_resend;
        logic [1:0]  status;
        logic [6:0]  window_size;
        logic [6:0]  fifo_fill;
        logic [31:0] lost_count;
    } t_gbn_out;

    // Decoded command, one-hot
    typedef struct packed {
        logic is_new;
        logic is_tick;
        logic is_ack;
        logic is_nack;
    } t_gbn_kind;

    // Entry of the queue between front and back
    typedef struct packed {
        t_gbn_kind   kind;
        logic [31:0] payload_tag;
        logic [15:0] peer_seq;
    } t_gbn_job;

endpackage

### hw/rtl/gbn_front.sv
// Go-Back-N sender front: takes commands, decodes them and queues them.
// Depends on gbn_pkg; feeds gbn_back through a two-entry queue.
`timescale 1ns / 1ps

module gbn_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  gbn_pkg::t_gbn_in i_item,
    output logic             o_job_valid,
    output gbn_pkg::t_gbn_job o_job,
    input  logic             i_job_pop
);
    import gbn_pkg::*;

    localparam int QDEPTH = 2;

    t_gbn_job    r_slot [QDEPTH];
    logic        r_wr_ptr, r_rd_ptr;
    logic [1:0]  r_cnt;
    logic        push;
    t_gbn_job    job_in;

    // Decode the command into a one-hot kind
    always_comb begin
        job_in.kind        = '0;
        job_in.payload_tag = i_item.payload_tag;
        job_in.peer_seq    = i_item.peer_seq;
        unique case (i_item.cmd)
            CMD_NEW:  job_in.kind.is_new  = 1'b1;
            CMD_TICK: job_in.kind.is_tick = 1'b1;
            CMD_ACK:  job_in.kind.is_ack  = 1'b1;
            CMD_NACK: job_in.kind.is_nack = 1'b1;
            default:  job_in.kind.is_tick = 1'b1;
        endcase
    end

    assign busy        = (r_cnt == 2'(QDEPTH));
    assign push        = start && !busy;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_slot[r_rd_ptr];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= job_in;
        end
    end

    // Queue pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_job_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_job_pop);
        end
    end

endmodule

### hw/rtl/gbn_back.sv
// Go-Back-N sender back end: sequencer, window state, wait FIFO and resend store.
// Depends on gbn_pkg; takes decoded jobs from gbn_front.
`timescale 1ns / 1ps

module gbn_back #(
    parameter int WAIT_DEPTH  = 64,
    parameter int STORE_DEPTH = 64,
    parameter int SEQ_BITS    = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_qlim_on,
    input  logic [6:0]         i_qlim,
    input  logic               i_job_valid,
    input  gbn_pkg::t_gbn_job  i_job,
    output logic               o_job_pop,
    output logic               o_result_valid,
    output gbn_pkg::t_gbn_out  o_result
);
    import gbn_pkg::*;

    localparam int SW    = SEQ_BITS;
    localparam int SA_W  = $clog2(STORE_DEPTH);
    localparam int WA_W  = $clog2(WAIT_DEPTH);
    localparam int CNT_W = $clog2(WAIT_DEPTH + 1);
    localparam int LIM_W = (CNT_W > 7) ? CNT_W : 7;
    localparam longint unsigned SEQ_MAX = (64'd1 << SEQ_BITS) - 64'd1;
    localparam int CAP   = (64'(STORE_DEPTH) < SEQ_MAX) ? STORE_DEPTH : int'(SEQ_MAX);
    localparam int WIN_W = $clog2(CAP + 1);

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLASS = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // Slot arithmetic: one add and one conditional subtract
    function automatic logic [SA_W-1:0] store_wrap(input logic [SA_W-1:0] b,
                                                   input logic [WIN_W-1:0] o);
        logic [SA_W+1:0] s;
        s = (SA_W+2)'(b) + (SA_W+2)'(o);
        if (s >= (SA_W+2)'(STORE_DEPTH)) begin
            s = s - (SA_W+2)'(STORE_DEPTH);
        end
        return s[SA_W-1:0];
    endfunction

    function automatic logic [WA_W-1:0] wait_wrap(input logic [WA_W-1:0] b,
                                                  input logic [CNT_W-1:0] o);
        logic [WA_W+1:0] s;
        s = (WA_W+2)'(b) + (WA_W+2)'(o);
        if (s >= (WA_W+2)'(WAIT_DEPTH)) begin
            s = s - (WA_W+2)'(WAIT_DEPTH);
        end
        return s[WA_W-1:0];
    endfunction

    // Architectural state
    logic [1:0]       r_state, n_state;
    logic [1:0]       r_mode, n_mode;
    logic [SW-1:0]    r_next, n_next;
    logic [SW-1:0]    r_acked, n_acked;
    logic [SA_W-1:0]  r_base, n_base;
    logic [WIN_W-1:0] r_ridx, n_ridx;
    logic [WIN_W-1:0] r_rtot, n_rtot;
    logic [WA_W-1:0]  r_whead, n_whead;
    logic [CNT_W-1:0] r_wcount, n_wcount;
    logic [31:0]      r_drop, n_drop;

    // Per-job working registers
    t_gbn_job         r_job;
    logic [WIN_W-1:0] r_win, r_d, r_dm1, n_win;
    logic             r_ack_ok, r_store_room, r_q_room;
    logic [SA_W-1:0]  r_wslot;
    logic [WA_W-1:0]  r_wq_waddr;
    logic [SW-1:0]    r_rs_seq;
    logic [31:0]      r_st_rd, r_wq_rd;

    logic [31:0]      r_store_mem [STORE_DEPTH];
    logic [31:0]      r_wait_mem  [WAIT_DEPTH];

    // Classification terms
    logic [SW-1:0]    win_full, d_full, dm1_full;
    logic [LIM_W-1:0] limit;
    logic [SA_W-1:0]  st_raddr;
    logic             is_idle, resend_go;
    logic             st_we, wq_we;
    logic [31:0]      st_wdata;
    logic [1:0]       stat;
    t_gbn_out         n_res;

    assign win_full = r_next - r_acked;
    assign d_full   = SW'(r_job.peer_seq) - r_acked;
    assign dm1_full = SW'(r_job.peer_seq) + ~r_acked;
    assign limit    = (i_qlim_on && (LIM_W'(i_qlim) < LIM_W'(WAIT_DEPTH)))
                      ? LIM_W'(i_qlim) : LIM_W'(WAIT_DEPTH);
    assign st_raddr = store_wrap(r_base, r_job.kind.is_nack ? r_dm1 : r_ridx);
    assign is_idle  = (r_mode != MODE_NEW) && (r_mode != MODE_RESEND);
    assign resend_go = (r_ridx < r_rtot) && (r_ridx < r_win);

    // Sequencer: pop, classify, read memories, commit
    assign o_job_pop = i_job_valid && ((r_state == ST_IDLE) || (r_state == ST_DONE));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  n_state = o_job_pop ? ST_CLASS : ST_IDLE;
            ST_CLASS: n_state = ST_READ;
            ST_READ:  n_state = ST_DONE;
            ST_DONE:  n_state = o_job_pop ? ST_CLASS : ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Per-job registers: window checks, then addresses
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
        if (r_state == ST_CLASS) begin
            r_win        <= WIN_W'(win_full);
            r_d          <= WIN_W'(d_full);
            r_dm1        <= WIN_W'(dm1_full);
            r_ack_ok     <= (d_full != '0) && (d_full <= win_full);
            r_store_room <= (win_full < SW'(CAP));
            r_q_room     <= (LIM_W'(r_wcount) < limit);
        end
        if (r_state == ST_READ) begin
            r_wslot    <= store_wrap(r_base, r_win);
            r_wq_waddr <= wait_wrap(r_whead, r_wcount);
            r_rs_seq   <= r_acked + SW'(r_ridx) + SW'(1);
        end
    end

    // Resend store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store_mem[r_wslot] <= st_wdata;
        end
        if (r_state == ST_READ) begin
            r_st_rd <= r_store_mem[st_raddr];
        end
    end

    // Wait FIFO: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wq_we) begin
            r_wait_mem[r_wq_waddr] <= r_job.payload_tag;
        end
        if (r_state == ST_READ) begin
            r_wq_rd <= r_wait_mem[r_whead];
        end
    end

    // Commit step: state update and result
    always_comb begin
        n_mode   = r_mode;
        n_next   = r_next;
        n_acked  = r_acked;
        n_base   = r_base;
        n_ridx   = r_ridx;
        n_rtot   = r_rtot;
        n_whead  = r_whead;
        n_wcount = r_wcount;
        n_drop   = r_drop;
        n_win    = r_win;
        st_we    = 1'b0;
        st_wdata = r_job.payload_tag;
        wq_we    = 1'b0;
        stat     = STAT_OK;
        n_res    = '0;
        if (r_state == ST_DONE) begin
            priority if (r_job.kind.is_new) begin
                if (is_idle) begin
                    if (r_store_room) begin
                        st_we            = 1'b1;
                        n_next           = r_next + SW'(1);
                        n_win            = r_win + WIN_W'(1);
                        n_mode           = MODE_NEW;
                        n_res.send_valid = 1'b1;
                        n_res.send_seq   = 16'(n_next);
                        n_res.send_tag   = r_job.payload_tag;
                    end else begin
                        stat = STAT_SFULL;
                    end
                end else if (r_q_room) begin
                    wq_we    = 1'b1;
                    n_wcount = r_wcount + CNT_W'(1);
                end else begin
                    n_drop = r_drop + 32'd1;
                    stat   = STAT_QFULL;
                end
            end else if (r_job.kind.is_tick) begin
                if ((r_mode == MODE_RESEND) && resend_go) begin
                    // next frame of a resend run
                    n_ridx           = r_ridx + WIN_W'(1);
                    n_res.send_valid = 1'b1;
                    n_res.send_seq   = 16'(r_rs_seq);
                    n_res.send_tag   = r_st_rd;
                    n_res.is_resend  = 1'b1;
                end else if (!is_idle) begin
                    // serve the wait FIFO
                    if (r_wcount == '0) begin
                        n_mode = MODE_IDLE;
                    end else begin
                        n_whead  = wait_wrap(r_whead, CNT_W'(1));
                        n_wcount = r_wcount - CNT_W'(1);
                        if (r_store_room) begin
                            st_we            = 1'b1;
                            st_wdata         = r_wq_rd;
                            n_next           = r_next + SW'(1);
                            n_win            = r_win + WIN_W'(1);
                            n_mode           = MODE_NEW;
                            n_res.send_valid = 1'b1;
                            n_res.send_seq   = 16'(n_next);
                            n_res.send_tag   = r_wq_rd;
                        end else begin
                            stat   = STAT_SFULL;
                            n_mode = (r_wcount != CNT_W'(1)) ? MODE_NEW : MODE_IDLE;
                        end
                    end
                end
            end else if (!r_ack_ok) begin
                stat = STAT_STALE;
            end else if (r_job.kind.is_ack) begin
                n_acked = r_acked + SW'(r_d);
                n_base  = store_wrap(r_base, r_d);
                n_win   = r_win - r_d;
                if (r_mode == MODE_RESEND) begin
                    n_rtot = (r_rtot > r_d) ? r_rtot - r_d : '0;
                    n_ridx = (r_ridx > r_d) ? r_ridx - r_d : '0;
                end
            end else begin
                // NACK: release up to peer-1, resend the whole window
                n_acked = r_acked + SW'(r_dm1);
                n_base  = store_wrap(r_base, r_dm1);
                n_win   = r_win - r_dm1;
                n_rtot  = r_win - r_dm1;
                n_ridx  = '0;
                n_mode  = MODE_RESEND;
                if (is_idle) begin
                    n_ridx           = WIN_W'(1);
                    n_res.send_valid = 1'b1;
                    n_res.send_seq   = 16'(SW'(r_job.peer_seq));
                    n_res.send_tag   = r_st_rd;
                    n_res.is_resend  = 1'b1;
                end
            end
        end
        n_res.status      = stat;
        n_res.window_size = 7'(n_win);
        n_res.fifo_fill   = 7'(n_wcount);
        n_res.lost_count  = n_drop;
    end

    // Control and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mode   <= MODE_IDLE;
            r_next   <= '0;
            r_acked  <= '0;
            r_base   <= '0;
            r_ridx   <= '0;
            r_rtot   <= '0;
            r_whead  <= '0;
            r_wcount <= '0;
            r_drop   <= '0;
            o_result_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_next   <= n_next;
            r_acked  <= n_acked;
            r_base   <= n_base;
            r_ridx   <= n_ridx;
            r_rtot   <= n_rtot;
            r_whead  <= n_whead;
            r_wcount <= n_wcount;
            r_drop   <= n_drop;
            o_result_valid <= (r_state == ST_DONE);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE) begin
            o_result <= n_res;
        end
    end

endmodule

### hw/rtl/go_back_n_sender.sv
// Go-Back-N ARQ sender top level: configuration registers, front and back.
// Depends on gbn_pkg, gbn_front and gbn_back.
`timescale 1ns / 1ps

// Usage:
//   Commands enter on i_item (new payload, transmission done, ACK, NACK) and
//   are taken at a rising edge with start high and busy low. A two-entry queue
//   sits between the decode front and the back end, so up to two further
//   commands can be taken while one is being worked on.
//   Every command gives exactly one result on o_result, marked by a
//   single-cycle o_result_valid; the receiver must take it in that cycle.
//   A taken command waits in the queue, then the back-end sequencer works on
//   it alone (classify, registered read of the wait FIFO and resend store,
//   commit) before the result register; it pops the next one at commit.
//   Configuration: i_cfg_we writes register i_cfg_idx (0 queue limit enable,
//   1 queue limit) at once; write only while no command is in flight.
//   Reset (synchronous, active low) empties the window, the wait FIFO and the
//   queue, clears the drop count and restores the configuration defaults.
//   Store and FIFO contents are not cleared; they are only read once written.
module go_back_n_sender #(
    parameter int WAIT_DEPTH  = 64,
    parameter int STORE_DEPTH = 64,
    parameter int SEQ_BITS    = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  gbn_pkg::t_gbn_in                i_item,
    output logic                            o_result_valid,
    output gbn_pkg::t_gbn_out               o_result,
    input  logic                            i_cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gbn_pkg::CFG_W-1:0]       i_cfg_data
);
    import gbn_pkg::*;

    logic             r_qlim_on;
    logic [CFG_W-1:0] r_qlim;
    logic             job_valid, job_pop;
    t_gbn_job         job;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlim_on <= 1'b0;
            r_qlim    <= QLIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_QLIM_ON: r_qlim_on <= i_cfg_data[0];
                REG_QLIM:    r_qlim    <= i_cfg_data;
                default:     r_qlim    <= r_qlim;
            endcase
        end
    end

    gbn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    gbn_back #(
        .WAIT_DEPTH  (WAIT_DEPTH),
        .STORE_DEPTH (STORE_DEPTH),
        .SEQ_BITS    (SEQ_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_qlim_on      (r_qlim_on),
        .i_qlim         (r_qlim),
        .i_job_valid    (job_valid),
        .i_job          (job),
        .o_job_pop      (job_pop),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

`ifndef SYNTH
    // Results never come back to back; each command passes classify, read and commit
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("results on consecutive cycles");

    // A launched frame always reports ok
    a_send_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.send_valid) |-> (o_result.status == STAT_OK))
        else $error("frame launched with non-ok status");

    // A resend flag only comes with a launched frame
    a_resend_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.is_resend) |-> o_result.send_valid)
        else $error("resend flag without a frame");

    // A pop only happens with data in the queue
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> job_valid)
        else $error("queue popped while empty");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for the Go-Back-N sender (go_back_n_sender).
// Runs a directed table and then random phases against a built-in predictor of the sender.
// Depends on gbn_pkg and the go_back_n_sender RTL only.
`timescale 1ns / 1ps

module testbench;
    import gbn_pkg::*;

    localparam int WAIT_D  = 64;
    localparam int STORE_D = 64;

    typedef struct {
        t_gbn_in  item;
        bit       typed;
        t_gbn_out want;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    logic                 busy;
    t_gbn_in              i_item     = '0;
    logic                 o_result_valid;
    t_gbn_out             o_result;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    go_back_n_sender u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Predicted sender state
    logic [1:0]  m_mode       = MODE_IDLE;
    logic [15:0] m_next_seq   = '0;
    logic [15:0] m_acked      = '0;
    int unsigned m_rs_idx     = 0;
    int unsigned m_rs_total   = 0;
    logic [31:0] m_wait_fifo [WAIT_D];
    int unsigned m_wait_head  = 0;
    int unsigned m_wait_cnt   = 0;
    logic [31:0] m_frame_store [STORE_D];
    int unsigned m_store_base = 0;
    logic [31:0] m_lost       = '0;
    logic        m_qlim_on    = 1'b0;
    logic [6:0]  m_qlim       = QLIM_RESET;

    t_gbn_out    outcomes_due [$];
    t_row        plan [$];
    int unsigned n_bad        = 0;
    int unsigned n_results    = 0;

    // Frames sent but not yet acknowledged
    function automatic int unsigned in_flight();
        logic [15:0] w;
        w = m_next_seq - m_acked;
        return 32'(w);
    endfunction

    // Store a fresh frame and launch it, unless the store is full
    function automatic bit launch_fresh(logic [31:0] tag, inout t_gbn_out r);
        int unsigned w;
        w = in_flight();
        if (w >= STORE_D) return 1'b0;
        m_frame_store[(m_store_base + w) % STORE_D] = tag;
        m_next_seq  = m_next_seq + 16'd1;
        r.send_valid = 1'b1;
        r.send_seq   = m_next_seq;
        r.send_tag   = tag;
        r.is_resend  = 1'b0;
        return 1'b1;
    endfunction

    function automatic void relaunch(inout t_gbn_out r);
        r.send_valid = 1'b1;
        r.send_seq   = m_acked + 16'd1 + 16'(m_rs_idx);
        r.send_tag   = m_frame_store[(m_store_base + m_rs_idx) % STORE_D];
        r.is_resend  = 1'b1;
        m_rs_idx++;
    endfunction

    // Take the FIFO head and send it; drop it if the store is full, go idle if empty
    function automatic logic [1:0] pop_wait_fifo(inout t_gbn_out r);
        logic [31:0] tag;
        if (m_wait_cnt == 0) begin
            m_mode = MODE_IDLE;
            return STAT_OK;
        end
        tag         = m_wait_fifo[m_wait_head];
        m_wait_head = (m_wait_head + 1) % WAIT_D;
        m_wait_cnt--;
        if (launch_fresh(tag, r)) begin
            m_mode = MODE_NEW;
            return STAT_OK;
        end
        m_mode = (m_wait_cnt != 0) ? MODE_NEW : MODE_IDLE;
        return STAT_SFULL;
    endfunction

    function automatic void slide_base(int unsigned n);
        m_acked      = m_acked + 16'(n);
        m_store_base = (m_store_base + n) % STORE_D;
    endfunction

    // Expected result of one command; advances the predicted state
    function automatic t_gbn_out predict_outcome(t_gbn_in it);
        t_gbn_out    r;
        int unsigned lim;
        int unsigned w;
        int unsigned d;
        logic [15:0] seq_gap;
        logic [1:0]  st;
        bit          was_idle;
        r        = '0;
        was_idle = (m_mode != MODE_NEW) && (m_mode != MODE_RESEND);
        case (it.cmd)
            CMD_NEW: begin
                if (was_idle) begin
                    if (launch_fresh(it.payload_tag, r)) m_mode = MODE_NEW;
                    else r.status = STAT_SFULL;
                end else begin
                    lim = WAIT_D;
                    if (m_qlim_on && m_qlim < lim) lim = m_qlim;
                    if (m_wait_cnt < lim) begin
                        m_wait_fifo[(m_wait_head + m_wait_cnt) % WAIT_D] = it.payload_tag;
                        m_wait_cnt++;
                    end else begin
                        m_lost++;
                        r.status = STAT_QFULL;
                    end
                end
            end
            CMD_TICK: begin
                if (m_mode == MODE_NEW) begin
                    st = pop_wait_fifo(r);
                    r.status = st;
                end else if (m_mode == MODE_RESEND) begin
                    if (m_rs_idx >= m_rs_total || m_rs_idx >= in_flight()) begin
                        st = pop_wait_fifo(r);
                        r.status = st;
                    end else begin
                        relaunch(r);
                    end
                end
            end
            default: begin
                w       = in_flight();
                seq_gap = it.peer_seq - m_acked;
                d       = 32'(seq_gap);
                if (d == 0 || d > w) begin
                    r.status = STAT_STALE;
                end else if (it.cmd == CMD_ACK) begin
                    slide_base(d);
                    if (m_mode == MODE_RESEND) begin
                        m_rs_total = (m_rs_total > d) ? m_rs_total - d : 0;
                        m_rs_idx   = (m_rs_idx > d) ? m_rs_idx - d : 0;
                    end
                end else begin
                    // NACK: release up to peer-1, then resend the whole window
                    slide_base(d - 1);
                    m_rs_total = in_flight();
                    m_rs_idx   = 0;
                    if (was_idle) relaunch(r);
                    m_mode = MODE_RESEND;
                end
            end
        endcase
        r.window_size = 7'(in_flight());
        r.fifo_fill   = 7'(m_wait_cnt);
        r.lost_count  = m_lost;
        return r;
    endfunction

    function automatic void add_row(logic [1:0] c, logic [31:0] tag, logic [15:0] peer,
                                    bit typed, t_gbn_out want);
        t_row row;
        row.item.cmd         = c;
        row.item.payload_tag = tag;
        row.item.peer_seq    = peer;
        row.typed            = typed;
        row.want             = want;
        plan.push_back(row);
    endfunction

    // Random command, mostly well-formed ACK/NACKs inside the window
    function automatic t_gbn_in pick_item(int new_pct, int tick_pct, int ack_pct);
        t_gbn_in     it;
        int unsigned r;
        int unsigned w;
        it.payload_tag = $urandom();
        it.peer_seq    = 16'($urandom());
        r = $urandom_range(0, 99);
        if (r < new_pct)                          it.cmd = CMD_NEW;
        else if (r < new_pct + tick_pct)          it.cmd = CMD_TICK;
        else if (r < new_pct + tick_pct + ack_pct) it.cmd = CMD_ACK;
        else                                      it.cmd = CMD_NACK;
        if (it.cmd == CMD_ACK || it.cmd == CMD_NACK) begin
            w = in_flight();
            if (w != 0 && $urandom_range(0, 9) != 0)
                it.peer_seq = m_acked + 16'($urandom_range(1, w));
        end
        return it;
    endfunction

    task automatic flag_mismatch(string what);
        n_bad++;
        $display("mismatch: %s", what);
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                    n_results, name, got, want));
    endtask

    // Offer one command and wait for its transfer
    task automatic offer(t_gbn_in it, bit typed, t_gbn_out want);
        t_gbn_out guess;
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        guess = predict_outcome(it);
        outcomes_due.push_back(typed ? want : guess);
    endtask

    task automatic rest(int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge i_clk);
    endtask

    // Both registers, one per cycle, while nothing is in flight
    task automatic set_limits(bit on, logic [6:0] lim);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_QLIM_ON;
        i_cfg_data <= {6'd0, on};
        @(posedge i_clk);
        i_cfg_idx  <= REG_QLIM;
        i_cfg_data <= lim;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        m_qlim_on = on;
        m_qlim    = lim;
    endtask

    task automatic run_phase(int items, bit on, int lim, int new_pct, int tick_pct,
                             int ack_pct, bit calm);
        int unsigned gap_pct;
        gap_pct = 0;
        drain();
        set_limits(on, 7'(lim));
        for (int n = 0; n < items; n++) begin
            offer(pick_item(new_pct, tick_pct, ack_pct), 1'b0, '0);
            if (!calm) begin
                if (n % 40 == 0) gap_pct = 25 * $urandom_range(0, 2);
                if ($urandom_range(0, 199) == 0) drain();
                else if ($urandom_range(0, 99) < gap_pct) rest($urandom_range(1, 10));
            end
        end
    endtask

    // Result checker: the receiver always takes the transfer
    always @(posedge i_clk) begin
        t_gbn_out want;
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (outcomes_due.size() == 0) begin
                flag_mismatch($sformatf("result %0d with nothing pending", n_results));
            end else begin
                want = outcomes_due.pop_front();
                compare_field("send_valid",  32'(o_result.send_valid),
                              32'(want.send_valid));
                compare_field("send_seq",    32'(o_result.send_seq), 32'(want.send_seq));
                compare_field("send_tag",    o_result.send_tag,      want.send_tag);
                compare_field("is_resend",   32'(o_result.is_resend),
                              32'(want.is_resend));
                compare_field("status",      32'(o_result.status),   32'(want.status));
                compare_field("window_size", 32'(o_result.window_size),
                              32'(want.window_size));
                compare_field("fifo_fill",   32'(o_result.fifo_fill),
                              32'(want.fifo_fill));
                compare_field("lost_count",  o_result.lost_count,    want.lost_count);
            end
            n_results++;
        end
    end

    initial begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    initial begin
        int unsigned waited;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty window, stale peers, queueing, NACK and ACK during resend
        add_row(CMD_TICK, 32'd0, 16'd0, 1'b1,
                {1'b0, 16'd0, 32'd0, 1'b0, STAT_OK, 7'd0, 7'd0, 32'd0});
        add_row(CMD_ACK, 32'd0, 16'd0, 1'b1,
                {1'b0, 16'd0, 32'd0, 1'b0, STAT_STALE, 7'd0, 7'd0, 32'd0});
        add_row(CMD_NACK, 32'd0, 16'hFFFF, 1'b1,
                {1'b0, 16'd0, 32'd0, 1'b0, STAT_STALE, 7'd0, 7'd0, 32'd0});
        add_row(CMD_NEW, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                {1'b1, 16'd1, 32'hFFFF_FFFF, 1'b0, STAT_OK, 7'd1, 7'd0, 32'd0});
        add_row(CMD_NEW, 32'd0, 16'd0, 1'b1,
                {1'b0, 16'd0, 32'd0, 1'b0, STAT_OK, 7'd1, 7'd1, 32'd0});
        add_row(CMD_NEW, 32'hA5A5_5A5A, 16'd0, 1'b0, '0);
        add_row(CMD_TICK, 32'd0, 16'd0, 1'b1,
                {1'b1, 16'd2, 32'd0, 1'b0, STAT_OK, 7'd2, 7'd1, 32'd0});
        add_row(CMD_TICK, 32'd0, 16'd0, 1'b0, '0);
        add_row(CMD_TICK, 32'd0, 16'd0, 1'b0, '0);
        add_row(CMD_ACK, 32'd0, 16'd1, 1'b0, '0);
        add_row(CMD_NACK, 32'd0, 16'd3, 1'b0, '0);
        add_row(CMD_NEW, 32'h0000_1234, 16'd0, 1'b0, '0);
        add_row(CMD_NACK, 32'd0, 16'd3, 1'b0, '0);
        add_row(CMD_TICK, 32'd0, 16'd0, 1'b0, '0);
        add_row(CMD_ACK, 32'd0, 16'd3, 1'b0, '0);
        add_row(CMD_TICK, 32'd0, 16'd0, 1'b0, '0);
        add_row(CMD_NEW, 32'h8000_0001, 16'hFFFF, 1'b0, '0);
        add_row(CMD_ACK, 32'd0, 16'hFFFF, 1'b1,
                {1'b0, 16'd0, 32'd0, 1'b0, STAT_STALE, 7'd1, 7'd1, 32'd0});
        add_row(CMD_NACK, 32'd0, 16'd4, 1'b0, '0);
        add_row(CMD_ACK, 32'd0, 16'd4, 1'b0, '0);
        add_row(CMD_TICK, 32'd0, 16'd0, 1'b0, '0);
        add_row(CMD_TICK, 32'd0, 16'd0, 1'b0, '0);
        foreach (plan[i]) begin
            offer(plan[i].item, plan[i].typed, plan[i].want);
            if ($urandom_range(0, 9) < 3) rest($urandom_range(1, 10));
        end

        // Random phases: queue limit zero and one, flooding, store pressure, mixed
        run_phase(120, 1'b1, 0,  40, 35, 15, 1'b0);
        run_phase(120, 1'b1, 1,  45, 30, 15, 1'b0);
        run_phase(160, 1'b0, 0,  75, 15,  7, 1'b0);
        run_phase(200, 1'b1, 64, 48, 50,  1, 1'b0);
        run_phase(150, 1'b1, $urandom_range(2, 63), 35, 35, 18, 1'b0);
        run_phase(100, 1'b0, 64, 40, 40, 12, 1'b1);

        // Let the last results out, then watch for strays
        start <= 1'b0;
        waited = 0;
        while (outcomes_due.size() != 0 && waited < 200) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (outcomes_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", outcomes_due.size()));
        if (n_bad == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
